### rtl/core/gbm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gbm_pkg - shared definitions of the geofence breach monitor
// Coordinate widths, queue sizing, register indexes and the words passed
// between the classification front end and the state back end.
// ============================================================================
package gbm_pkg;

    // Coordinate width in millimetres, two's complement.
    localparam int COORD_BITS = 21;
    // Width of the unsigned extents (half sizes and radius).
    localparam int EXT_BITS   = COORD_BITS - 1;
    // Width of a squared extent.
    localparam int SQ_W       = 2 * EXT_BITS;

    // Number of register stages in the classification pipeline.
    localparam int FRONT_STAGES = 3;
    // Depth of the queue between front and back.
    localparam int QDEPTH       = 8;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    // Width that holds queued plus in-flight words.
    localparam int CRED_W       = $clog2(QDEPTH + FRONT_STAGES + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAPE_IS_CIRCLE  = 3'd0,
        CFG_CENTER_X         = 3'd1,
        CFG_CENTER_Y         = 3'd2,
        CFG_HALF_WIDTH       = 3'd3,
        CFG_HALF_HEIGHT      = 3'd4,
        CFG_RADIUS           = 3'd5,
        CFG_ALTITUDE_CEILING = 3'd6
    } t_cfg_index;

    // Classified tick, as handed from the front end to the back end.
    typedef struct packed {
        logic in_zone;
        logic pos_valid;
        logic armed;
        logic mode_is_land;
    } t_class;

    // One result word.
    typedef struct packed {
        logic contained;
        logic breach_event;
        logic land_request;
        logic guard_cleared;
        logic breach_latched;
    } t_result;

endpackage

### rtl/core/gbm_front.sv
`timescale 1ns / 1ps
// ============================================================================
// gbm_front - fence classification pipeline
// Holds the fence configuration and tests each accepted position against the
// rectangle or circle and the altitude ceiling in three register stages.
// ============================================================================
module gbm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gbm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbm_pkg::COORD_BITS-1:0]  i_cfg_wdata,
    input  logic                            i_push,
    input  logic signed [gbm_pkg::COORD_BITS-1:0] i_pos_x,
    input  logic signed [gbm_pkg::COORD_BITS-1:0] i_pos_y,
    input  logic signed [gbm_pkg::COORD_BITS-1:0] i_pos_z,
    input  logic                            i_position_valid,
    input  logic                            i_armed,
    input  logic                            i_mode_is_land,
    output logic                            o_valid,
    output gbm_pkg::t_class                 o_word,
    output logic [gbm_pkg::CRED_W-1:0]      o_inflight
);
    import gbm_pkg::*;

    // Configuration registers.
    logic                          r_shape_is_circle;
    logic signed [COORD_BITS-1:0]  r_center_x;
    logic signed [COORD_BITS-1:0]  r_center_y;
    logic [EXT_BITS-1:0]           r_half_width;
    logic [EXT_BITS-1:0]           r_half_height;
    logic [EXT_BITS-1:0]           r_radius;
    logic signed [COORD_BITS-1:0]  r_altitude_ceiling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_is_circle  <= 1'b0;
            r_center_x         <= '0;
            r_center_y         <= '0;
            r_half_width       <= EXT_BITS'(3000);
            r_half_height      <= EXT_BITS'(3000);
            r_radius           <= EXT_BITS'(3000);
            r_altitude_ceiling <= COORD_BITS'(2000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SHAPE_IS_CIRCLE:  r_shape_is_circle  <= i_cfg_wdata[0];
                CFG_CENTER_X:         r_center_x         <= i_cfg_wdata;
                CFG_CENTER_Y:         r_center_y         <= i_cfg_wdata;
                CFG_HALF_WIDTH:       r_half_width       <= i_cfg_wdata[EXT_BITS-1:0];
                CFG_HALF_HEIGHT:      r_half_height      <= i_cfg_wdata[EXT_BITS-1:0];
                CFG_RADIUS:           r_radius           <= i_cfg_wdata[EXT_BITS-1:0];
                CFG_ALTITUDE_CEILING: r_altitude_ceiling <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1: absolute offsets from the center and the ceiling test.
    logic signed [COORD_BITS:0] dx_diff;
    logic signed [COORD_BITS:0] dy_diff;
    logic [COORD_BITS-1:0]      dx_abs;
    logic [COORD_BITS-1:0]      dy_abs;

    assign dx_diff = $signed({i_pos_x[COORD_BITS-1], i_pos_x})
                   - $signed({r_center_x[COORD_BITS-1], r_center_x});
    assign dy_diff = $signed({i_pos_y[COORD_BITS-1], i_pos_y})
                   - $signed({r_center_y[COORD_BITS-1], r_center_y});
    assign dx_abs  = dx_diff[COORD_BITS] ? COORD_BITS'(-dx_diff) : COORD_BITS'(dx_diff);
    assign dy_abs  = dy_diff[COORD_BITS] ? COORD_BITS'(-dy_diff) : COORD_BITS'(dy_diff);

    logic                  r_s1_vld;
    logic [COORD_BITS-1:0] r_s1_dx;
    logic [COORD_BITS-1:0] r_s1_dy;
    logic                  r_s1_z_ok;
    t_class                r_s1_flags;

    // Stage 2: rectangle test, circle bounding test and the three squares.
    logic [EXT_BITS-1:0] dx_t;
    logic [EXT_BITS-1:0] dy_t;
    logic [SQ_W-1:0]     dx_sq;
    logic [SQ_W-1:0]     dy_sq;
    logic [SQ_W-1:0]     r_sq;

    // The products only matter when both offsets are within the radius,
    // so the offsets fit the extent width there.
    assign dx_t  = r_s1_dx[EXT_BITS-1:0];
    assign dy_t  = r_s1_dy[EXT_BITS-1:0];
    assign dx_sq = SQ_W'(dx_t) * SQ_W'(dx_t);
    assign dy_sq = SQ_W'(dy_t) * SQ_W'(dy_t);
    assign r_sq  = SQ_W'(r_radius) * SQ_W'(r_radius);

    logic            r_s2_vld;
    logic            r_s2_rect_ok;
    logic            r_s2_box_ok;
    logic            r_s2_z_ok;
    logic [SQ_W-1:0] r_s2_dx_sq;
    logic [SQ_W-1:0] r_s2_dy_sq;
    logic [SQ_W-1:0] r_s2_r_sq;
    t_class          r_s2_flags;

    // Stage 3: squared distance against squared radius, shape select.
    logic [SQ_W:0] dist_sq;
    logic          circle_ok;
    logic          xy_ok;

    assign dist_sq   = (SQ_W+1)'(r_s2_dx_sq) + (SQ_W+1)'(r_s2_dy_sq);
    assign circle_ok = r_s2_box_ok && (dist_sq <= (SQ_W+1)'(r_s2_r_sq));
    assign xy_ok     = r_shape_is_circle ? circle_ok : r_s2_rect_ok;

    logic   r_s3_vld;
    t_class r_s3_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_push;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dx    <= dx_abs;
        r_s1_dy    <= dy_abs;
        r_s1_z_ok  <= (i_pos_z <= r_altitude_ceiling);
        r_s1_flags <= {1'b0, i_position_valid, i_armed, i_mode_is_land};

        r_s2_rect_ok <= (r_s1_dx <= COORD_BITS'(r_half_width))
                     && (r_s1_dy <= COORD_BITS'(r_half_height));
        r_s2_box_ok  <= (r_s1_dx <= COORD_BITS'(r_radius))
                     && (r_s1_dy <= COORD_BITS'(r_radius));
        r_s2_z_ok    <= r_s1_z_ok;
        r_s2_dx_sq   <= dx_sq;
        r_s2_dy_sq   <= dy_sq;
        r_s2_r_sq    <= r_sq;
        r_s2_flags   <= r_s1_flags;

        r_s3_word <= {xy_ok && r_s2_z_ok, r_s2_flags.pos_valid, r_s2_flags.armed,
                      r_s2_flags.mode_is_land};
    end

    assign o_valid    = r_s3_vld;
    assign o_word     = r_s3_word;
    assign o_inflight = CRED_W'(r_s1_vld) + CRED_W'(r_s2_vld) + CRED_W'(r_s3_vld);

endmodule

### rtl/core/gbm_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// gbm_queue - queue of classified words
// A small circular buffer that decouples the classification pipeline from
// the state back end.
// ============================================================================
module gbm_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  gbm_pkg::t_class             i_wr_word,
    input  logic                        i_rd,
    output logic                        o_rd_valid,
    output gbm_pkg::t_class             o_rd_word,
    output logic [gbm_pkg::QCNT_W-1:0]  o_count
);
    import gbm_pkg::*;

    t_class              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        ptr_next = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_rd) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_word;
        end
    end

    assign o_rd_valid = (r_count != '0);
    assign o_rd_word  = r_mem[r_rd_ptr];
    assign o_count    = r_count;

endmodule

### rtl/core/gbm_back.sv
`timescale 1ns / 1ps
// ============================================================================
// gbm_back - breach latch and result register
// Applies each classified word to the outside memory and the breach latch
// and holds the result word until the receiver takes it.
// ============================================================================
module gbm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_valid,
    input  gbm_pkg::t_class   i_rd_word,
    output logic              o_rd,
    input  logic              i_pop,
    output logic              o_out_valid,
    output gbm_pkg::t_result  o_result
);
    import gbm_pkg::*;

    logic    r_was_outside;
    logic    r_breach_latch;
    logic    r_out_valid;
    t_result r_result;

    logic    take;
    logic    event_hit;
    logic    latch_mid;
    logic    cleared;
    logic    n_was_outside;
    logic    n_breach_latch;
    t_result n_result;

    assign take = i_rd_valid && (!r_out_valid || i_pop);

    always_comb begin
        event_hit      = !i_rd_word.in_zone && !r_was_outside && i_rd_word.armed;
        latch_mid      = r_breach_latch || event_hit;
        cleared        = !i_rd_word.armed && latch_mid;
        n_was_outside  = cleared ? 1'b0 : !i_rd_word.in_zone;
        n_breach_latch = cleared ? 1'b0 : latch_mid;

        n_result.contained      = i_rd_word.in_zone;
        n_result.breach_event   = event_hit;
        n_result.land_request   = latch_mid && i_rd_word.armed && !i_rd_word.mode_is_land;
        n_result.guard_cleared  = cleared;
        n_result.breach_latched = n_breach_latch;

        // A tick without a position leaves the state alone and reports zeros.
        if (!i_rd_word.pos_valid) begin
            n_was_outside  = r_was_outside;
            n_breach_latch = r_breach_latch;
            n_result       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_outside  <= 1'b0;
            r_breach_latch <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (take) begin
                r_was_outside  <= n_was_outside;
                r_breach_latch <= n_breach_latch;
                r_out_valid    <= 1'b1;
            end else if (i_pop) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_rd        = take;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### rtl/core/geofence_breach_monitor.sv
`timescale 1ns / 1ps
// ============================================================================
// geofence_breach_monitor - geofence containment check with breach latch
// Tests each monitoring tick against a rectangular or circular fence and an
// altitude ceiling, latches breaches while armed and requests landing.
// ============================================================================
// Usage:
//   Input words are pushed with i_push while o_full is low; each word is one
//   tick with a position, a position-valid flag, the armed flag and the
//   land-mode flag. Result words are read with o_empty and i_pop: while
//   o_empty is low the oldest result sits on the o_ ports, and a cycle with
//   i_pop high takes it. Exactly one result word comes out per input word,
//   in order.
//   Each word passes through three classification stages and the queue
//   into the result register. Throughput is one word per cycle while
//   o_full is low; the squared-distance multipliers are pipelined so they
//   never limit the rate.
//   When the receiver stalls, words keep flowing into an eight-entry queue;
//   o_full rises once queued and in-flight words would fill it, so nothing
//   is ever dropped. o_full depends only on internal state.
//   Configuration registers are written through i_cfg_we, i_cfg_index and
//   i_cfg_wdata while the block is idle; unknown indexes are ignored.
//   Synchronous reset restores the register defaults (rectangle of 3000 mm
//   half extents at the origin, ceiling 2000 mm), clears the breach latch
//   and the outside memory, and empties the queue and result register.
// ============================================================================
module geofence_breach_monitor (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [gbm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gbm_pkg::COORD_BITS-1:0]       i_cfg_wdata,
    // Input words
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic signed [gbm_pkg::COORD_BITS-1:0] i_pos_x,
    input  logic signed [gbm_pkg::COORD_BITS-1:0] i_pos_y,
    input  logic signed [gbm_pkg::COORD_BITS-1:0] i_pos_z,
    input  logic                                 i_position_valid,
    input  logic                                 i_armed,
    input  logic                                 i_mode_is_land,
    // Result words
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic                                 o_contained,
    output logic                                 o_breach_event,
    output logic                                 o_land_request,
    output logic                                 o_guard_cleared,
    output logic                                 o_breach_latched
);
    import gbm_pkg::*;

    logic              accept;
    logic              front_valid;
    t_class            front_word;
    logic [CRED_W-1:0] inflight;
    logic [QCNT_W-1:0] q_count;
    logic [CRED_W-1:0] credit;
    logic              q_rd_valid;
    t_class            q_rd_word;
    logic              back_rd;
    logic              out_valid;
    t_result           result;

    // Every accepted word is guaranteed a queue slot: words in flight in the
    // front end are counted as already queued.
    assign credit = CRED_W'(q_count) + inflight;
    assign o_full = (credit >= CRED_W'(QDEPTH));
    assign accept = i_push && !o_full;

    gbm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_push           (accept),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_position_valid (i_position_valid),
        .i_armed          (i_armed),
        .i_mode_is_land   (i_mode_is_land),
        .o_valid          (front_valid),
        .o_word           (front_word),
        .o_inflight       (inflight)
    );

    gbm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (front_valid),
        .i_wr_word  (front_word),
        .i_rd       (back_rd),
        .o_rd_valid (q_rd_valid),
        .o_rd_word  (q_rd_word),
        .o_count    (q_count)
    );

    gbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_valid  (q_rd_valid),
        .i_rd_word   (q_rd_word),
        .o_rd        (back_rd),
        .i_pop       (i_pop),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign o_empty          = !out_valid;
    assign o_contained      = result.contained;
    assign o_breach_event   = result.breach_event;
    assign o_land_request   = result.land_request;
    assign o_guard_cleared  = result.guard_cleared;
    assign o_breach_latched = result.breach_latched;

endmodule
